>>> design/fks_pkg.sv
`timescale 1ns / 1ps

package fks_pkg;

    localparam int DEF_CAPACITY = 8;
    localparam int DEF_KEY_BITS = 32;

    localparam int KIND_W   = 2;
    localparam int KEY_IN_W = 32;
    localparam int VALUE_W  = 64;
    localparam int POS_W    = 3;

    // transaction kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    // per-cell command
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHIFT,
        OP_LOAD,
        OP_UPD
    } t_cell_op;

endpackage

>>> design/fks_cell.sv
`timescale 1ns / 1ps

module fks_cell
    import fks_pkg::*;
#(
    parameter int KEY_W = DEF_KEY_BITS
) (
    input  logic               i_clk,
    input  t_cell_op           i_op,
    input  logic [KEY_W-1:0]   i_nb_key,
    input  logic [VALUE_W-1:0] i_nb_value,
    input  logic [KEY_W-1:0]   i_ld_key,
    input  logic [VALUE_W-1:0] i_ld_value,
    output logic [KEY_W-1:0]   o_key,
    output logic [VALUE_W-1:0] o_value
);

    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_HOLD: begin
            end
            OP_SHIFT: begin
                r_key   <= i_nb_key;
                r_value <= i_nb_value;
            end
            OP_LOAD: begin
                r_key   <= i_ld_key;
                r_value <= i_ld_value;
            end
            OP_UPD: begin
                r_value <= i_ld_value;
            end
            default: begin
            end
        endcase
    end

    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

>>> design/fifo_keyed_store_with_writeback.sv
`timescale 1ns / 1ps

// Small fully associative key/value store kept in insertion order, cell 0 holding
// the oldest entry. Each transaction is taken while idle and then executed;
// insert, remove and unused kinds give one result each, and a flush gives one
// result per stored entry (at least one). The execute step waits while the
// result register is still occupied and stalled downstream; a new input
// transaction is taken as soon as the previous one has finished executing.
// Entries live in a chain of CAPACITY cells: every cell compares its key with the
// incoming key in parallel, and the chain can shift toward the head. Eviction of
// the oldest entry on a full-store miss comes out as a writeback in the insert's
// single result. A flush rotates the chain once per entry, emitting the head each
// time, so the store ends up in its original order.

module fifo_keyed_store_with_writeback
    import fks_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [KEY_IN_W-1:0] i_key,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [POS_W-1:0]    i_remove_position,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_status,
    output logic                o_hit,
    output logic                o_writeback_valid,
    output logic [KEY_IN_W-1:0] o_writeback_key,
    output logic [VALUE_W-1:0]  o_writeback_value,
    output logic                o_last
);

    // stored key width: only the low KEY_BITS of the 32-bit key take part
    localparam int SKW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    // entry count width
    localparam int CW  = $clog2(CAPACITY + 1);
    // width for position compares
    localparam int PW  = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;

    // captured transaction
    logic [KIND_W-1:0]   r_kind;
    logic [SKW-1:0]      r_key;
    logic [VALUE_W-1:0]  r_value;
    logic [POS_W-1:0]    r_pos;

    // result register
    logic                r_o_valid, n_o_valid;
    logic                r_status, n_status;
    logic                r_hit, n_hit;
    logic                r_wb_valid, n_wb_valid;
    logic [KEY_IN_W-1:0] r_wb_key, n_wb_key;
    logic [VALUE_W-1:0]  r_wb_value, n_wb_value;
    logic                r_last, n_last;

    // cell chain
    t_cell_op            cell_op  [CAPACITY];
    logic [SKW-1:0]      cell_key [CAPACITY];
    logic [VALUE_W-1:0]  cell_val [CAPACITY];
    logic [CAPACITY-1:0] match;
    logic                sel_head;
    logic [SKW-1:0]      ld_key;
    logic [VALUE_W-1:0]  ld_value;

    logic in_acc;
    logic out_free;
    logic full;
    logic any_hit;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_o_valid || !i_out_stall;
    assign full     = (r_count == CW'(CAPACITY));
    assign any_hit  = |match;

    // during a flush the head is written back into the tail of the live entries
    assign ld_key   = sel_head ? cell_key[0] : r_key;
    assign ld_value = sel_head ? cell_val[0] : r_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [SKW-1:0]     nb_key;
        logic [VALUE_W-1:0] nb_value;

        if (g == CAPACITY - 1) begin : g_tail
            assign nb_key   = '0;
            assign nb_value = '0;
        end else begin : g_mid
            assign nb_key   = cell_key[g+1];
            assign nb_value = cell_val[g+1];
        end

        fks_cell #(
            .KEY_W(SKW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_op      (cell_op[g]),
            .i_nb_key  (nb_key),
            .i_nb_value(nb_value),
            .i_ld_key  (ld_key),
            .i_ld_value(ld_value),
            .o_key     (cell_key[g]),
            .o_value   (cell_val[g])
        );

        // live entries only; keys of live entries are unique
        assign match[g] = (CW'(g) < r_count) && (cell_key[g] == r_key);
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_left     = r_left;
        n_o_valid  = r_o_valid && i_out_stall;
        n_status   = r_status;
        n_hit      = r_hit;
        n_wb_valid = r_wb_valid;
        n_wb_key   = r_wb_key;
        n_wb_value = r_wb_value;
        n_last     = r_last;
        sel_head   = 1'b0;
        for (int j = 0; j < CAPACITY; j++) begin
            cell_op[j] = OP_HOLD;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_status   = 1'b0;
                    n_hit      = 1'b0;
                    n_wb_valid = 1'b0;
                    n_wb_key   = '0;
                    n_wb_value = '0;
                    n_last     = 1'b1;
                    n_state    = S_IDLE;
                    unique case (r_kind)
                        KIND_INSERT: begin
                            if (any_hit) begin
                                n_hit = 1'b1;
                                for (int j = 0; j < CAPACITY; j++) begin
                                    if (match[j]) begin
                                        cell_op[j] = OP_UPD;
                                    end
                                end
                            end else if (full) begin
                                // evict the oldest, shift down, append at the tail
                                n_wb_valid = 1'b1;
                                n_wb_key   = KEY_IN_W'(cell_key[0]);
                                n_wb_value = cell_val[0];
                                for (int j = 0; j < CAPACITY; j++) begin
                                    cell_op[j] = (j == CAPACITY - 1) ? OP_LOAD : OP_SHIFT;
                                end
                            end else begin
                                n_count = r_count + CW'(1);
                                for (int j = 0; j < CAPACITY; j++) begin
                                    if (CW'(j) == r_count) begin
                                        cell_op[j] = OP_LOAD;
                                    end
                                end
                            end
                        end
                        KIND_REMOVE: begin
                            if (PW'(r_pos) >= PW'(r_count)) begin
                                n_status = 1'b1;
                            end else begin
                                n_count = r_count - CW'(1);
                                for (int j = 0; j < CAPACITY; j++) begin
                                    if (PW'(j) >= PW'(r_pos)) begin
                                        cell_op[j] = OP_SHIFT;
                                    end
                                end
                            end
                        end
                        KIND_FLUSH: begin
                            if (r_count != '0) begin
                                // first entry of the flush, rotate the chain by one
                                n_wb_valid = 1'b1;
                                n_wb_key   = KEY_IN_W'(cell_key[0]);
                                n_wb_value = cell_val[0];
                                n_last     = (r_count == CW'(1));
                                n_left     = r_count - CW'(1);
                                n_state    = (r_count == CW'(1)) ? S_IDLE : S_FLUSH;
                                sel_head   = 1'b1;
                                for (int j = 0; j < CAPACITY; j++) begin
                                    if (CW'(j) < r_count - CW'(1)) begin
                                        cell_op[j] = OP_SHIFT;
                                    end else if (CW'(j) == r_count - CW'(1)) begin
                                        cell_op[j] = OP_LOAD;
                                    end
                                end
                            end
                        end
                        default: begin
                            // unused kind: plain acknowledge
                        end
                    endcase
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_status   = 1'b0;
                    n_hit      = 1'b0;
                    n_wb_valid = 1'b1;
                    n_wb_key   = KEY_IN_W'(cell_key[0]);
                    n_wb_value = cell_val[0];
                    n_last     = (r_left == CW'(1));
                    n_left     = r_left - CW'(1);
                    n_state    = (r_left == CW'(1)) ? S_IDLE : S_FLUSH;
                    sel_head   = 1'b1;
                    for (int j = 0; j < CAPACITY; j++) begin
                        if (CW'(j) < r_count - CW'(1)) begin
                            cell_op[j] = OP_SHIFT;
                        end else if (CW'(j) == r_count - CW'(1)) begin
                            cell_op[j] = OP_LOAD;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        // payload, no reset needed
        if (in_acc) begin
            r_kind  <= i_kind;
            r_key   <= i_key[SKW-1:0];
            r_value <= i_value;
            r_pos   <= i_remove_position;
        end
        r_left     <= n_left;
        r_status   <= n_status;
        r_hit      <= n_hit;
        r_wb_valid <= n_wb_valid;
        r_wb_key   <= n_wb_key;
        r_wb_value <= n_wb_value;
        r_last     <= n_last;

        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_o_valid;
    assign o_status          = r_status;
    assign o_hit             = r_hit;
    assign o_writeback_valid = r_wb_valid;
    assign o_writeback_key   = r_wb_key;
    assign o_writeback_value = r_wb_value;
    assign o_last            = r_last;

    // occupancy never exceeds the chain length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a flush never changes the number of stored entries
    a_flush_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> $stable(r_count))
        else $error("entry count changed during flush");

    // a key hit updates in place and never evicts
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> !o_writeback_valid)
        else $error("writeback on key hit");

    // only flush produces more than one result, each carrying an entry
    a_multi_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_writeback_valid && !o_hit && !o_status))
        else $error("non-final result without writeback");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fks_pkg::*;

    // kind code the block does not define, answered with an empty result
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    // status codes of a result
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_POS = 1'b1;

    localparam int STORE_DEPTH    = DEF_CAPACITY;
    localparam int ITEMS_PER_PASS = 52;
    localparam int HOLD_OFF_LEN   = 150;
    localparam int DRAIN_CYCLES   = 16;

    // one result transaction as seen on the output ports
    typedef struct packed {
        logic                status;
        logic                hit;
        logic                wb_valid;
        logic [KEY_IN_W-1:0] wb_key;
        logic [VALUE_W-1:0]  wb_value;
        logic                last;
    } t_result;

    // one row of the directed table; typed rows carry their expected single result
    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [KEY_IN_W-1:0] key;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    pos;
        bit                  typed;
        logic                w_status;
        logic                w_hit;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [KIND_W-1:0]   i_kind;
    logic [KEY_IN_W-1:0] i_key;
    logic [VALUE_W-1:0]  i_value;
    logic [POS_W-1:0]    i_remove_position;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_status;
    logic                o_hit;
    logic                o_writeback_valid;
    logic [KEY_IN_W-1:0] o_writeback_key;
    logic [VALUE_W-1:0]  o_writeback_value;
    logic                o_last;

    fifo_keyed_store_with_writeback DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_key             (i_key),
        .i_value           (i_value),
        .i_remove_position (i_remove_position),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_hit             (o_hit),
        .o_writeback_valid (o_writeback_valid),
        .o_writeback_key   (o_writeback_key),
        .o_writeback_value (o_writeback_value),
        .o_last            (o_last)
    );

    // shadow copy of the store, oldest entry at index 0
    logic [KEY_IN_W-1:0] shadow_keys [STORE_DEPTH];
    logic [VALUE_W-1:0]  shadow_values [STORE_DEPTH];
    int                  shadow_count;

    t_result  step_results[$];      // results of the transaction just predicted
    t_result  expected_results[$];  // results still owed by the block, oldest first
    t_dir_row directed_rows[$];
    logic [KEY_IN_W-1:0] key_pool [12];

    int error_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;

    // free-running clock, 4 ns period
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("FAIL fifo_keyed_store_with_writeback");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] expv);
        $display("mismatch %s: got %h expected %h at %0t", what, got, expv, $realtime);
        error_count++;
    endtask

    // close the gap left by the entry at position pos
    task automatic drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i]   = shadow_keys[i + 1];
            shadow_values[i] = shadow_values[i + 1];
        end
        shadow_count--;
    endtask

    // advance the shadow store by one input transaction, collecting its results
    task automatic predict_store(input logic [KIND_W-1:0] kind,
                                 input logic [KEY_IN_W-1:0] key,
                                 input logic [VALUE_W-1:0] value,
                                 input logic [POS_W-1:0] pos);
        t_result r;
        int      hit_at;
        int      i;
        step_results.delete();
        r      = '0;
        r.last = 1'b1;
        case (kind)
            KIND_INSERT: begin
                // parallel compare over all live entries
                hit_at = -1;
                for (i = 0; i < shadow_count; i++) begin
                    if (shadow_keys[i] == key) hit_at = i;
                end
                if (hit_at >= 0) begin
                    shadow_values[hit_at] = value;
                    r.hit = 1'b1;
                end else begin
                    // full store: oldest entry goes out with this result
                    if (shadow_count >= STORE_DEPTH) begin
                        r.wb_valid = 1'b1;
                        r.wb_key   = shadow_keys[0];
                        r.wb_value = shadow_values[0];
                        drop_entry(0);
                    end
                    shadow_keys[shadow_count]   = key;
                    shadow_values[shadow_count] = value;
                    shadow_count++;
                end
                step_results.push_back(r);
            end
            KIND_REMOVE: begin
                if (pos >= shadow_count) r.status = STATUS_BAD_POS;
                else drop_entry(pos);
                step_results.push_back(r);
            end
            KIND_FLUSH: begin
                if (shadow_count == 0) begin
                    step_results.push_back(r);
                end else begin
                    // one writeback per entry, oldest first, store left intact
                    for (i = 0; i < shadow_count; i++) begin
                        r.wb_valid = 1'b1;
                        r.wb_key   = shadow_keys[i];
                        r.wb_value = shadow_values[i];
                        r.last     = (i + 1 == shadow_count);
                        step_results.push_back(r);
                    end
                end
            end
            default: begin
                step_results.push_back(r);
            end
        endcase
    endtask

    task automatic add_row(input logic [KIND_W-1:0] kind, input logic [KEY_IN_W-1:0] key,
                           input logic [VALUE_W-1:0] value, input logic [POS_W-1:0] pos,
                           input bit typed, input logic w_status, input logic w_hit);
        t_dir_row row;
        row.kind     = kind;
        row.key      = key;
        row.value    = value;
        row.pos      = pos;
        row.typed    = typed;
        row.w_status = w_status;
        row.w_hit    = w_hit;
        directed_rows.push_back(row);
    endtask

    // offer one input transaction, starting and ending at a falling edge
    task automatic send_item(input t_dir_row row);
        t_result typed_result;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_kind            <= row.kind;
        i_key             <= row.key;
        i_value           <= row.value;
        i_remove_position <= row.pos;
        // accepted at the first rising edge with stall low
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_store(row.kind, row.key, row.value, row.pos);
        if (row.typed) begin
            typed_result        = '0;
            typed_result.status = row.w_status;
            typed_result.hit    = row.w_hit;
            typed_result.last   = 1'b1;
            expected_results.push_back(typed_result);
        end else begin
            foreach (step_results[i]) expected_results.push_back(step_results[i]);
        end
        @(negedge i_clk);
    endtask

    // random transaction; keys mostly from a small pool so hits and evictions happen
    task automatic send_random;
        t_dir_row row;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 58)      row.kind = KIND_INSERT;
        else if (pick < 80) row.kind = KIND_REMOVE;
        else if (pick < 94) row.kind = KIND_FLUSH;
        else                row.kind = KIND_UNUSED;
        if ($urandom_range(0, 99) < 70) row.key = key_pool[$urandom_range(0, 11)];
        else                            row.key = $urandom;
        row.value = {$urandom, $urandom};
        row.pos   = POS_W'($urandom_range(0, 7));
        row.typed = 1'b0;
        send_item(row);
    endtask

    // receiver: random stall, or a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_out_stall     <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", 64'(o_writeback_key), 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_hit !== want.hit)
                    report_mismatch("hit", 64'(o_hit), 64'(want.hit));
                if (o_writeback_valid !== want.wb_valid)
                    report_mismatch("writeback_valid", 64'(o_writeback_valid),
                                    64'(want.wb_valid));
                if (o_writeback_key !== want.wb_key)
                    report_mismatch("writeback_key", 64'(o_writeback_key),
                                    64'(want.wb_key));
                if (o_writeback_value !== want.wb_value)
                    report_mismatch("writeback_value", o_writeback_value, want.wb_value);
                if (o_last !== want.last)
                    report_mismatch("last", 64'(o_last), 64'(want.last));
            end
        end
    end

    initial begin
        // known values on every input from time zero
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_kind            = KIND_INSERT;
        i_key             = '0;
        i_value           = '0;
        i_remove_position = '0;
        i_out_stall       = 1'b0;
        error_count       = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_off_cycles   = 0;
        shadow_count      = 0;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 12; i++) key_pool[i] = $urandom;

        // directed table: empty store first, then fill, evict, remove, flush
        add_row(KIND_REMOVE, 32'h0, 64'h0, 3'd0, 1'b1, STATUS_BAD_POS, 1'b0);
        add_row(KIND_FLUSH, 32'h0, 64'h0, 3'd0, 1'b1, STATUS_OK, 1'b0);
        add_row(KIND_UNUSED, 32'h0, 64'h0, 3'd0, 1'b1, STATUS_OK, 1'b0);
        add_row(KIND_INSERT, 32'h0, 64'h0, 3'd0, 1'b1, STATUS_OK, 1'b0);
        add_row(KIND_INSERT, 32'hFFFF_FFFF, '1, 3'd7, 1'b1, STATUS_OK, 1'b0);
        // same key again: in-place update
        add_row(KIND_INSERT, 32'h0, 64'h0123_4567_89AB_CDEF, 3'd0, 1'b1, STATUS_OK, 1'b1);
        add_row(KIND_FLUSH, 32'h0, 64'h0, 3'd0, 1'b0, STATUS_OK, 1'b0);
        // fill the store to capacity
        for (int i = 1; i <= 6; i++)
            add_row(KIND_INSERT, 32'h8000_0000 | i, {$urandom, $urandom}, 3'd0,
                    1'b0, STATUS_OK, 1'b0);
        // miss on a full store evicts the oldest entry
        add_row(KIND_INSERT, 32'h0000_0100, 64'h8000_0000_0000_0001, 3'd0,
                1'b0, STATUS_OK, 1'b0);
        add_row(KIND_INSERT, 32'hFFFF_FFFF, 64'h0, 3'd0, 1'b0, STATUS_OK, 1'b0);
        add_row(KIND_FLUSH, 32'h0, 64'h0, 3'd0, 1'b0, STATUS_OK, 1'b0);
        // remove the newest, then the same position is out of range
        add_row(KIND_REMOVE, 32'h0, 64'h0, 3'd7, 1'b0, STATUS_OK, 1'b0);
        add_row(KIND_REMOVE, 32'h0, 64'h0, 3'd7, 1'b0, STATUS_OK, 1'b0);
        add_row(KIND_REMOVE, 32'h0, 64'h0, 3'd0, 1'b0, STATUS_OK, 1'b0);
        add_row(KIND_REMOVE, '1, '1, 3'd3, 1'b0, STATUS_OK, 1'b0);
        add_row(KIND_FLUSH, '1, '1, 3'd7, 1'b0, STATUS_OK, 1'b0);
        add_row(KIND_UNUSED, '1, '1, 3'd7, 1'b1, STATUS_OK, 1'b0);

        // synchronous reset, released on a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) send_item(directed_rows[i]);

        // random passes with different idling on each side
        for (int pass = 0; pass < 4; pass++) begin
            case (pass)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    // long receiver hold-off so the block backs up into its input
                    hold_off_cycles = HOLD_OFF_LEN;
                end
                1: begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default: begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PASS; n++) send_random();
        end
        i_in_valid <= 1'b0;

        // drain, then keep watching for anything unexpected
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("PASS fifo_keyed_store_with_writeback");
        end else begin
            $display("FAIL fifo_keyed_store_with_writeback");
        end
        $finish;
    end

endmodule
